// File: rtl/core/bba_pkg.sv
`default_nettype none

package bba_pkg;

    // Sequencer states of the accumulator
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTENT,
        S_SQUARE,
        S_START,
        S_ROOT,
        S_DONE
    } bba_state_t;

    // Number of axes and the last step of the squaring pass
    localparam int unsigned NUM_AXES = 3;
    localparam logic [1:0]  SQ_LAST  = 2'd3;

    // Axis codes used by the squaring pass
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/bba_box.sv
`default_nettype none

module bba_box #(
    parameter int unsigned CB = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 fresh,
    input  wire logic signed [CB-1:0] px,
    input  wire logic signed [CB-1:0] py,
    input  wire logic signed [CB-1:0] pz,
    output logic signed [CB-1:0]      min_x,
    output logic signed [CB-1:0]      min_y,
    output logic signed [CB-1:0]      min_z,
    output logic signed [CB-1:0]      max_x,
    output logic signed [CB-1:0]      max_y,
    output logic signed [CB-1:0]      max_z
);

    logic                 started_reg;
    logic                 restart;
    logic signed [CB-1:0] min_reg [bba_pkg::NUM_AXES];
    logic signed [CB-1:0] max_reg [bba_pkg::NUM_AXES];
    logic signed [CB-1:0] pt      [bba_pkg::NUM_AXES];

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    // Start a new box on a flagged word or when no point has been seen yet
    assign restart = fresh || !started_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else if (load)
        begin
            started_reg <= 1'b1;
        end
    end

    // Widen or restart the box, one comparator pair per axis
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < bba_pkg::NUM_AXES; i++)
            begin
                if (restart)
                begin
                    min_reg[i] <= pt[i];
                    max_reg[i] <= pt[i];
                end
                else
                begin
                    if (pt[i] < min_reg[i])
                    begin
                        min_reg[i] <= pt[i];
                    end
                    if (pt[i] > max_reg[i])
                    begin
                        max_reg[i] <= pt[i];
                    end
                end
            end
        end
    end

    assign min_x = min_reg[0];
    assign min_y = min_reg[1];
    assign min_z = min_reg[2];
    assign max_x = max_reg[0];
    assign max_y = max_reg[1];
    assign max_z = max_reg[2];

endmodule

`default_nettype wire

// File: rtl/core/bba_isqrt.sv
`default_nettype none

module bba_isqrt #(
    parameter int unsigned CB = 24
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*CB+1:0] radicand,
    output logic                 done,
    output logic [CB:0]          root
);

    localparam int unsigned CW = $clog2(CB + 1);

    logic            run_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*CB+1:0] work_reg;
    logic [CB+2:0]   rem_reg;
    logic [CB:0]     root_reg;

    logic [CB+2:0]   rem_shift;
    logic [CB+2:0]   trial;
    logic            fits;

    // Bring down the next pair of radicand bits and try the next root bit
    assign rem_shift = {rem_reg[CB:0], work_reg[2*CB+1:2*CB]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(CB);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance one root bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            work_reg <= {work_reg[2*CB-1:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[CB-1:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/bounding_box_accumulator.sv
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid/in_ready    point_x, point_y, point_z, first_of_set
// output   out_valid/out_ready  lower_*, upper_*, sphere_radius
//
// The square root unit, producing one root bit per cycle, sets most of the
// time that one word takes from acceptance to the next free slot.
// rst_n clears the sequencer, the result flag and the box-started flag.
// A finished result waits in the output register; a new word is taken while
// it waits, and only a second finished result stalls behind out_ready.
module bounding_box_accumulator #(
    parameter int unsigned COORD_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] point_z,
    input  wire logic                         first_of_set,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      lower_x,
    output logic signed [COORD_BITS-1:0]      lower_y,
    output logic signed [COORD_BITS-1:0]      lower_z,
    output logic signed [COORD_BITS-1:0]      upper_x,
    output logic signed [COORD_BITS-1:0]      upper_y,
    output logic signed [COORD_BITS-1:0]      upper_z,
    output logic [COORD_BITS-1:0]             sphere_radius
);

    localparam int unsigned CB = COORD_BITS;

    bba_pkg::bba_state_t state_reg, state_next;

    logic                 accept;
    logic                 load_out;
    logic                 root_start;
    logic                 root_done;
    logic [CB:0]          root;
    logic                 out_valid_reg;
    logic [1:0]           sq_cnt_reg, sq_cnt_next;

    logic signed [CB-1:0] min_x, min_y, min_z;
    logic signed [CB-1:0] max_x, max_y, max_z;

    logic [CB-1:0]        ext_reg [bba_pkg::NUM_AXES];
    logic [CB-1:0]        ext_sel;
    logic [2*CB-1:0]      ext_wide;
    logic [2*CB-1:0]      prod_reg;
    logic [2*CB+1:0]      sum_reg;

    logic signed [CB-1:0] lower_x_reg, lower_y_reg, lower_z_reg;
    logic signed [CB-1:0] upper_x_reg, upper_y_reg, upper_z_reg;
    logic [CB-1:0]        radius_reg;

    assign in_ready = (state_reg == bba_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    bba_box #(
        .CB (CB)
    ) u_box (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .fresh (first_of_set),
        .px    (point_x),
        .py    (point_y),
        .pz    (point_z),
        .min_x (min_x),
        .min_y (min_y),
        .min_z (min_z),
        .max_x (max_x),
        .max_y (max_y),
        .max_z (max_z)
    );

    bba_isqrt #(
        .CB (CB)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root)
    );

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next  = state_reg;
        sq_cnt_next = sq_cnt_reg;
        root_start  = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bba_pkg::S_EXTENT;
                end
            end
            bba_pkg::S_EXTENT:
            begin
                sq_cnt_next = '0;
                state_next  = bba_pkg::S_SQUARE;
            end
            bba_pkg::S_SQUARE:
            begin
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == bba_pkg::SQ_LAST)
                begin
                    state_next = bba_pkg::S_START;
                end
            end
            bba_pkg::S_START:
            begin
                root_start = 1'b1;
                state_next = bba_pkg::S_ROOT;
            end
            bba_pkg::S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_IDLE;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sq_cnt_reg <= sq_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pick the axis to square this cycle
    always_comb
    begin
        case (sq_cnt_reg)
            bba_pkg::AXIS_X: ext_sel = ext_reg[0];
            bba_pkg::AXIS_Y: ext_sel = ext_reg[1];
            bba_pkg::AXIS_Z: ext_sel = ext_reg[2];
            default:         ext_sel = '0;
        endcase
    end

    assign ext_wide = {{CB{1'b0}}, ext_sel};

    // Extents, then square one axis per cycle and add each registered product to the sum
    always_ff @(posedge clk)
    begin
        if (state_reg == bba_pkg::S_EXTENT)
        begin
            ext_reg[0] <= CB'(max_x - min_x);
            ext_reg[1] <= CB'(max_y - min_y);
            ext_reg[2] <= CB'(max_z - min_z);
            sum_reg    <= '0;
        end
        else if (state_reg == bba_pkg::S_SQUARE)
        begin
            prod_reg <= ext_wide * ext_wide;
            if (sq_cnt_reg != bba_pkg::AXIS_X)
            begin
                sum_reg <= sum_reg + {2'b00, prod_reg};
            end
        end
    end

    // Hold the finished word for the output side
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            lower_x_reg <= min_x;
            lower_y_reg <= min_y;
            lower_z_reg <= min_z;
            upper_x_reg <= max_x;
            upper_y_reg <= max_y;
            upper_z_reg <= max_z;
            radius_reg  <= root[CB:1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign lower_x       = lower_x_reg;
    assign lower_y       = lower_y_reg;
    assign lower_z       = lower_z_reg;
    assign upper_x       = upper_x_reg;
    assign upper_y       = upper_y_reg;
    assign upper_z       = upper_z_reg;
    assign sphere_radius = radius_reg;

endmodule

`default_nettype wire

// File: sim/bounding_box_accumulator_tb.sv
`timescale 1ns / 100ps

module bounding_box_accumulator_tb;

    localparam int COORD_W = 24;
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam int TARGET_WORDS = 1300;

    // Coordinate styles for random sets
    localparam int STYLE_FULL    = 0;
    localparam int STYLE_CLUSTER = 1;
    localparam int STYLE_EXTREME = 2;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      first;
        bit                        settle;
    } point_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] lower_x;
        logic signed [COORD_W-1:0] lower_y;
        logic signed [COORD_W-1:0] lower_z;
        logic signed [COORD_W-1:0] upper_x;
        logic signed [COORD_W-1:0] upper_y;
        logic signed [COORD_W-1:0] upper_z;
        logic [COORD_W-1:0]        radius;
    } box_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic signed [COORD_W-1:0] point_z = '0;
    logic first_of_set = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [COORD_W-1:0] lower_x;
    logic signed [COORD_W-1:0] lower_y;
    logic signed [COORD_W-1:0] lower_z;
    logic signed [COORD_W-1:0] upper_x;
    logic signed [COORD_W-1:0] upper_y;
    logic signed [COORD_W-1:0] upper_z;
    logic [COORD_W-1:0] sphere_radius;

    point_word_t point_queue[$];
    box_result_t box_expect[$];

    // Predicted box state
    logic signed [COORD_W-1:0] box_lo_x = '0, box_lo_y = '0, box_lo_z = '0;
    logic signed [COORD_W-1:0] box_hi_x = '0, box_hi_y = '0, box_hi_z = '0;
    bit box_open = 1'b0;

    int unsigned words_taken = 0;
    int unsigned results_checked = 0;
    int unsigned boxes_started = 0;
    int unsigned mismatches = 0;
    logic [COORD_W-1:0] widest_radius = '0;

    bit word_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    bounding_box_accumulator #(
        .COORD_BITS(COORD_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .first_of_set  (first_of_set),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lower_x       (lower_x),
        .lower_y       (lower_y),
        .lower_z       (lower_z),
        .upper_x       (upper_x),
        .upper_y       (upper_y),
        .upper_z       (upper_z),
        .sphere_radius (sphere_radius)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Truncated integer square root, two bits of the operand per step
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        int i;
        rem  = 0;
        root = 0;
        for (i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Fold one point into the box and queue the corners and radius it yields
    task automatic predict_box(input point_word_t w);
        box_result_t r;
        logic [COORD_W:0] ex;
        logic [COORD_W:0] ey;
        logic [COORD_W:0] ez;
        longint unsigned sum_sq;
        longint unsigned root;
        if (w.first || !box_open)
        begin
            box_lo_x = w.x;
            box_hi_x = w.x;
            box_lo_y = w.y;
            box_hi_y = w.y;
            box_lo_z = w.z;
            box_hi_z = w.z;
            box_open = 1'b1;
            boxes_started++;
        end
        else
        begin
            if (w.x < box_lo_x) box_lo_x = w.x;
            if (w.x > box_hi_x) box_hi_x = w.x;
            if (w.y < box_lo_y) box_lo_y = w.y;
            if (w.y > box_hi_y) box_hi_y = w.y;
            if (w.z < box_lo_z) box_lo_z = w.z;
            if (w.z > box_hi_z) box_hi_z = w.z;
        end
        ex = {box_hi_x[COORD_W-1], box_hi_x} - {box_lo_x[COORD_W-1], box_lo_x};
        ey = {box_hi_y[COORD_W-1], box_hi_y} - {box_lo_y[COORD_W-1], box_lo_y};
        ez = {box_hi_z[COORD_W-1], box_hi_z} - {box_lo_z[COORD_W-1], box_lo_z};
        sum_sq = 64'(ex) * 64'(ex) + 64'(ey) * 64'(ey) + 64'(ez) * 64'(ez);
        root = floor_root(sum_sq);
        r.lower_x = box_lo_x;
        r.lower_y = box_lo_y;
        r.lower_z = box_lo_z;
        r.upper_x = box_hi_x;
        r.upper_y = box_hi_y;
        r.upper_z = box_hi_z;
        r.radius  = COORD_W'(root >> 1);
        if (r.radius > widest_radius) widest_radius = r.radius;
        box_expect.insert(box_expect.size(), r);
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Mostly no idling, a few short gaps and the odd long one
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(
        input int style, input logic signed [COORD_W-1:0] centre);
        logic signed [COORD_W-1:0] v;
        case (style)
            STYLE_CLUSTER: v = centre + COORD_W'($signed($urandom_range(0, 2047)) - 1024);
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = '0;
                    3: v = '1;
                    default: v = COORD_W'($urandom);
                endcase
            end
            default: v = COORD_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_point(input logic signed [COORD_W-1:0] x, y, z,
                             input logic first, input bit settle = 1'b0);
        point_word_t w;
        w.x      = x;
        w.y      = y;
        w.z      = z;
        w.first  = first;
        w.settle = settle;
        point_queue.insert(point_queue.size(), w);
    endtask

    // Driver: present words at the falling edge, hold each until taken
    always @(negedge clk)
    begin
        point_word_t w;
        logic next_valid;
        next_valid = in_valid;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            word_taken = 1'b0;
            next_valid = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (point_queue.size() > 0 &&
                     !(point_queue[0].settle && box_expect.size() != 0))
            begin
                w = point_queue.pop_front();
                point_x      <= w.x;
                point_y      <= w.y;
                point_z      <= w.z;
                first_of_set <= w.first;
                next_valid   = 1'b1;
                send_gap     = pick_gap(send_quiet);
                if ($urandom_range(0, 149) == 0) send_quiet = !send_quiet;
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: stall out_ready at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap(recv_quiet);
            if ($urandom_range(0, 999) == 0) recv_quiet = !recv_quiet;
        end
    end

    // Monitor: predict on each accepted point, check each accepted result
    always @(posedge clk)
    begin
        point_word_t w;
        box_result_t e;
        if (rst_n && in_valid && in_ready)
        begin
            w.x      = point_x;
            w.y      = point_y;
            w.z      = point_z;
            w.first  = first_of_set;
            w.settle = 1'b0;
            predict_box(w);
            words_taken++;
            word_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (box_expect.size() == 0)
            begin
                $error("result word arrived with no point outstanding");
                mismatches++;
            end
            else
            begin
                e = box_expect.pop_front();
                check_field("lower_x", e.lower_x, lower_x);
                check_field("lower_y", e.lower_y, lower_y);
                check_field("lower_z", e.lower_z, lower_z);
                check_field("upper_x", e.upper_x, upper_x);
                check_field("upper_y", e.upper_y, upper_y);
                check_field("upper_z", e.upper_z, upper_z);
                check_field("sphere_radius", e.radius, sphere_radius);
                results_checked++;
            end
        end
    end

    initial
    begin
        int style;
        int len;
        int k;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic first;

        // Directed: no box yet, single points, extremes, one-sided widening
        add_point(5, -7, 9, 1'b0);
        add_point(5, -7, 9, 1'b0);
        add_point(0, 0, 0, 1'b1);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        add_point(0, 0, 0, 1'b0);
        add_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1);
        add_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        add_point(-1, 0, 0, 1'b1);
        add_point(1, 0, 0, 1'b0);
        add_point(0, 3, 0, 1'b0);
        add_point(-1, -1, -1, 1'b1);
        add_point(0, 0, 0, 1'b0);
        add_point(100, 100, 100, 1'b1);
        add_point(50, 100, 100, 1'b0);
        add_point(50, 200, 100, 1'b0);
        add_point(60, 150, 40, 1'b0);
        add_point(300, -300, 300, 1'b0);
        add_point(7, 7, 7, 1'b1);
        add_point(7, 7, 7, 1'b1);
        add_point(COORD_MAX, 0, COORD_MIN, 1'b0);

        // Random sets: a fresh box then widening points, with some noise
        while (point_queue.size() < TARGET_WORDS)
        begin
            style = $urandom_range(0, 9) < 5 ? STYLE_CLUSTER :
                    ($urandom_range(0, 3) == 0 ? STYLE_EXTREME : STYLE_FULL);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
            cz = COORD_W'($urandom);
            for (k = 0; k < len; k++)
            begin
                first = (k == 0);
                if ($urandom_range(0, 9) == 0) first = 1'($urandom_range(0, 1));
                add_point(pick_coord(style, cx), pick_coord(style, cy), pick_coord(style, cz),
                          first, k == 0 && $urandom_range(0, 39) == 0);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every word taken, every result back, then a short settle
        while (point_queue.size() != 0 || in_valid) @(posedge clk);
        while (box_expect.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Checked %0d results from %0d points over %0d boxes, widest radius %h.",
                 results_checked, words_taken, boxes_started, widest_radius);
        if (mismatches == 0 && box_expect.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results outstanding.", box_expect.size());
        $display("FAILURE");
        $finish;
    end

endmodule
